// ===== sv/framed_packet_sender_with_retry_assert.svh =====
// assertion macros shared by the framed packet sender checks
`ifndef FRAMED_PACKET_SENDER_WITH_RETRY_ASSERT_SVH
`define FRAMED_PACKET_SENDER_WITH_RETRY_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fps_pkg.sv =====
// shared types and constants of the framed packet sender
`default_nettype none

package fps_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;
  localparam int unsigned HDR_LEN         = 5;  // two preamble, two sync, length

  localparam logic [7:0]  PREAMBLE_BYTE   = 8'hAA;
  localparam logic [7:0]  ACK_CODE_RST    = 8'h00;
  localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;
  localparam logic [15:0] SYNC_WORD_RST   = {8'h2D, 8'hD4};

  localparam logic [1:0] CFG_ACK_CODE    = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] CFG_SYNC_WORD   = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_START,
    CMD_TICK,
    CMD_RESPONSE
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_DELIVERED,
    ST_FAILED,
    ST_REJECTED
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_WAIT
  } phase_t;

  typedef enum logic {
    STEP_RECV,
    STEP_EXEC
  } step_t;

  typedef struct packed {
    logic    load_item;
    logic    append;
    logic    start;
    logic    tick;
    logic    resend;
    logic    finish;
    logic    out_load;
    logic    res_tx;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic ack_match;
    logic full;
    logic retry_ok;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/framed_packet_sender_with_retry.sv =====
// top level of the framed packet sender with retry
// Stop-and-wait frame sender. Append items fill a payload buffer of MAX_PAYLOAD bytes;
// a start item opens a frame, and each ready-tick item then yields one frame byte
// (0xAA 0xAA, sync high, sync low, length, payload, 8-bit sum, 0xAA 0xAA, the last one
// flagged by frame_end). A response item is then checked against ack_code: a match
// reports delivered, a mismatch resends while retries remain, else reports failed.
// Every item gives exactly one result. An item is first accepted, issuing the buffer read,
// then executed with the registered read data from the payload ram once the result
// register is free. A result may wait in the output register while the next item is
// accepted. The payload ram needs no clearing after reset; settings may be written
// at any time the block is idle, and cfg_ready is high whenever reset is released.
`default_nettype none

module framed_packet_sender_with_retry #(
  parameter int unsigned MAX_PAYLOAD = fps_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_frame_end,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  fps_pkg::dp_cmd_t dp_cmd;
  fps_pkg::dp_sts_t dp_sts;

  assign cfg_ready = rst_n;

  fps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  fps_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .out_tx_valid  (out_tx_valid),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .out_status    (out_status)
  );

endmodule

`default_nettype wire

// ===== sv/fps_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module fps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/fps_ctrl.sv =====
// controller: item handshake and frame phase state machines
`default_nettype none

module fps_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire fps_pkg::dp_sts_t sts,
  output fps_pkg::dp_cmd_t     cmd
);

  fps_pkg::step_t  step_r,  step_nxt;
  fps_pkg::phase_t phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= fps_pkg::STEP_RECV;
      phase_r     <= fps_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    step_nxt       = step_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    cmd.res_status = fps_pkg::ST_NONE;
    case (step_r)
      fps_pkg::STEP_RECV: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          step_nxt      = fps_pkg::STEP_EXEC;
        end
      end
      fps_pkg::STEP_EXEC: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          step_nxt      = fps_pkg::STEP_RECV;
          case (sts.cmd)
            fps_pkg::CMD_APPEND: begin
              if (phase_r != fps_pkg::PH_IDLE || sts.full) begin
                cmd.res_status = fps_pkg::ST_REJECTED;
              end else begin
                cmd.append = 1'b1;
              end
            end
            fps_pkg::CMD_START: begin
              if (phase_r != fps_pkg::PH_IDLE) begin
                cmd.res_status = fps_pkg::ST_REJECTED;
              end else begin
                cmd.start = 1'b1;
                phase_nxt = fps_pkg::PH_SEND;
              end
            end
            fps_pkg::CMD_TICK: begin
              if (phase_r != fps_pkg::PH_SEND) begin
                cmd.res_status = fps_pkg::ST_REJECTED;
              end else begin
                cmd.tick   = 1'b1;
                cmd.res_tx = 1'b1;
                if (sts.last) begin
                  phase_nxt = fps_pkg::PH_WAIT;
                end
              end
            end
            fps_pkg::CMD_RESPONSE: begin
              if (phase_r != fps_pkg::PH_WAIT) begin
                cmd.res_status = fps_pkg::ST_REJECTED;
              end else if (sts.ack_match) begin
                cmd.finish     = 1'b1;
                cmd.res_status = fps_pkg::ST_DELIVERED;
                phase_nxt      = fps_pkg::PH_IDLE;
              end else if (sts.retry_ok) begin
                cmd.resend = 1'b1;
                phase_nxt  = fps_pkg::PH_SEND;
              end else begin
                cmd.finish     = 1'b1;
                cmd.res_status = fps_pkg::ST_FAILED;
                phase_nxt      = fps_pkg::PH_IDLE;
              end
            end
            default: begin
              cmd.res_status = fps_pkg::ST_REJECTED;
            end
          endcase
        end
      end
      default: begin
        step_nxt = fps_pkg::STEP_RECV;
      end
    endcase
  end

  // no item is taken while reset is held
  assign in_stall  = !rst_n || (step_r != fps_pkg::STEP_RECV);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/fps_datapath.sv =====
// datapath: settings, payload buffer, frame byte selection and result register
`default_nettype none

module fps_datapath #(
  parameter int unsigned MAX_PAYLOAD = fps_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       in_command,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire fps_pkg::dp_cmd_t cmd,
  output fps_pkg::dp_sts_t      sts,
  output logic                  out_tx_valid,
  output logic [7:0]            out_tx_byte,
  output logic                  out_frame_end,
  output logic [1:0]            out_status
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 8);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [PW-1:0] POS_SYNC_HI = PW'(2);
  localparam logic [PW-1:0] POS_SYNC_LO = PW'(3);
  localparam logic [PW-1:0] POS_LEN     = PW'(4);
  localparam logic [PW-1:0] HDR         = PW'(fps_pkg::HDR_LEN);
  localparam logic [PW-1:0] TRAIL_LAST  = PW'(2);
  localparam logic [CW-1:0] FULL_COUNT  = CW'(MAX_PAYLOAD);

  logic [7:0]  ack_code_r;
  logic [7:0]  max_retries_r;
  logic [15:0] sync_word_r;

  logic [CW-1:0] count_r,    count_nxt;
  logic [PW-1:0] pos_r,      pos_nxt;
  logic [7:0]    sum_r,      sum_nxt;
  logic [7:0]    attempts_r, attempts_nxt;

  fps_pkg::cmd_t item_cmd_r;
  logic [7:0]    item_data_r;

  logic             tx_valid_r;
  logic [7:0]       tx_byte_r;
  logic             frame_end_r;
  fps_pkg::status_t status_r;

  logic [PW-1:0] count_ext;
  logic [PW-1:0] data_end;
  logic [PW-1:0] pay_idx;
  logic          in_payload;
  logic          at_sum;
  logic          last;
  logic [7:0]    ram_rd_data;
  logic [7:0]    frame_byte;

  fps_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_buf (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (item_data_r),
    .rd_addr (pay_idx[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r    <= fps_pkg::ACK_CODE_RST;
      max_retries_r <= fps_pkg::MAX_RETRIES_RST;
      sync_word_r   <= fps_pkg::SYNC_WORD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fps_pkg::CFG_ACK_CODE:    ack_code_r    <= cfg_data[7:0];
        fps_pkg::CFG_MAX_RETRIES: max_retries_r <= cfg_data[7:0];
        fps_pkg::CFG_SYNC_WORD:   sync_word_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position decode; the buffer is read at the accept cycle so data is ready here
  assign count_ext  = PW'(count_r);
  assign data_end   = count_ext + HDR;
  assign pay_idx    = pos_r - HDR;
  assign in_payload = (pos_r >= HDR) && (pos_r < data_end);
  assign at_sum     = (pos_r == data_end);
  assign last       = (pos_r >= data_end + TRAIL_LAST);

  always_comb begin
    if (pos_r < POS_SYNC_HI) begin
      frame_byte = fps_pkg::PREAMBLE_BYTE;
    end else if (pos_r == POS_SYNC_HI) begin
      frame_byte = sync_word_r[15:8];
    end else if (pos_r == POS_SYNC_LO) begin
      frame_byte = sync_word_r[7:0];
    end else if (pos_r == POS_LEN) begin
      frame_byte = 8'(count_r);
    end else if (in_payload) begin
      frame_byte = ram_rd_data;
    end else if (at_sum) begin
      frame_byte = sum_r;
    end else begin
      frame_byte = fps_pkg::PREAMBLE_BYTE;
    end
  end

  always_comb begin
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    attempts_nxt = attempts_r;
    if (cmd.finish) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.start || cmd.resend) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end else if (cmd.tick) begin
      pos_nxt = last ? '0 : pos_r + PW'(1);
      if (in_payload) begin
        sum_nxt = sum_r + ram_rd_data;
      end
    end
    if (cmd.start) begin
      attempts_nxt = '0;
    end else if (cmd.resend) begin
      attempts_nxt = attempts_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      sum_r      <= '0;
      attempts_r <= '0;
    end else begin
      count_r    <= count_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      attempts_r <= attempts_nxt;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r  <= fps_pkg::cmd_t'(in_command);
      item_data_r <= in_data_byte;
    end
    if (cmd.out_load) begin
      tx_valid_r  <= cmd.res_tx;
      tx_byte_r   <= cmd.res_tx ? frame_byte : 8'h00;
      frame_end_r <= cmd.res_tx && last;
      status_r    <= cmd.res_status;
    end
  end

  assign sts.cmd       = item_cmd_r;
  assign sts.ack_match = (item_data_r == ack_code_r);
  assign sts.full      = (count_r == FULL_COUNT);
  assign sts.retry_ok  = (attempts_r < max_retries_r);
  assign sts.last      = last;

  assign out_tx_valid  = tx_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_frame_end = frame_end_r;
  assign out_status    = status_r;

endmodule

`default_nettype wire

// ===== sv/fps_checker.sv =====
// port-level checks of the framed packet sender, bound to the top level
`default_nettype none

`include "framed_packet_sender_with_retry_assert.svh"

module fps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_tx_valid,
  input wire logic [7:0]  out_tx_byte,
  input wire logic        out_frame_end,
  input wire logic [1:0]  out_status
);

  // a transmitted byte never carries a report
  `FPS_ASSERT_NOW(a_tx_no_status, out_valid && out_tx_valid,
                  out_status == fps_pkg::ST_NONE, "tx byte with status")

  // frame end only on a transmitted trailing preamble byte
  `FPS_ASSERT_NOW(a_end_is_trailer, out_valid && out_frame_end,
                  out_tx_valid && out_tx_byte == fps_pkg::PREAMBLE_BYTE, "bad frame end")

  // an accepted item is worked on before the next one is taken
  `FPS_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "item taken while busy")

  // a stalled result holds
  `FPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_tx_byte) && $stable(out_status),
                   "stalled result changed")

endmodule

bind framed_packet_sender_with_retry fps_checker u_chk (.*);

`default_nettype wire
